// ===== hdl/frame_deframer_with_source_learning_assert.svh =====
// -----------------------------------------------------------------------------
// Frame deframer assertion macros
// Shorthand for the concurrent checks used by the deframer checker.
// -----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_WITH_SOURCE_LEARNING_ASSERT_SVH
`define FRAME_DEFRAMER_WITH_SOURCE_LEARNING_ASSERT_SVH

// Check a same-cycle implication outside reset
`define FDSL_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Check a next-cycle implication outside reset
`define FDSL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

// Check what the cycle after a reset edge shows
`define FDSL_ASSERT_RST(name, clk, rst_n, cons) \
    name: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("deframer reset check failed");

`endif

// ===== hdl/fdsl_pkg.sv =====
// -----------------------------------------------------------------------------
// Frame deframer package
// Shared types, constants and command format of the deframer.
// -----------------------------------------------------------------------------
package fdsl_pkg;

    // Default sizes
    localparam int DEF_MAX_MESSAGE   = 64;
    localparam int DEF_TABLE_ENTRIES = 64;

    // Command queue between the front and the back (power of two)
    localparam int CMD_DEPTH = 4;

    // Framing bytes and register reset values
    localparam logic [7:0]  START_LOW        = 8'h80;
    localparam logic [7:0]  END_BYTE         = 8'hFF;
    localparam logic [15:0] PROTOCOL_RESET   = 16'h8820;
    localparam logic [6:0]  MIN_LENGTH_RESET = 7'd4;

    // Fixed field widths of the command format
    localparam int MSG_IDX_W  = 6;
    localparam int MSG_LEN_W  = 7;
    localparam int MAC_W      = 48;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTOCOL_TYPE = 2'd0,
        CFG_MIN_LENGTH    = 2'd1
    } t_cfg_reg;

    // Command kinds passed from front to back
    typedef enum logic {
        CMD_BYTE    = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic              action;
        logic [7:0]        data_byte;
        logic [15:0]       ether_type;
        logic [MAC_W-1:0]  source_mac;
        logic [SLOT_W-1:0] release_slot;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        message_byte;
        logic [SLOT_W-1:0] address_slot;
        logic              address_new;
        logic              table_full;
        logic              last_byte;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [7:0]           data;
        logic [MSG_IDX_W-1:0] index;
        logic                 deliver;
        logic [MSG_LEN_W-1:0] length;
        logic [MAC_W-1:0]     mac;
        logic [SLOT_W-1:0]    release_slot;
    } t_cmd;

endpackage

// ===== hdl/fdsl_front.sv =====
// -----------------------------------------------------------------------------
// Deframer front
// Filters and frames incoming bytes and turns each kept item into a command.
// -----------------------------------------------------------------------------
module fdsl_front
    import fdsl_pkg::*;
#(
    parameter int MAX_MESSAGE = DEF_MAX_MESSAGE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_item,
    input  logic                  i_accept,
    input  logic                  i_cfg_write,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cmd_valid,
    output t_cmd                  o_cmd
);

    localparam int FW = $clog2(MAX_MESSAGE + 1);

    logic [FW-1:0]        r_fill;
    logic [FW-1:0]        n_fill;
    logic [15:0]          r_protocol;
    logic [MSG_LEN_W-1:0] r_min_len;

    logic          is_release;
    logic          is_start;
    logic          is_end;
    logic          take_byte;
    logic          deliver;
    logic [FW-1:0] fill_inc;

    // Classify the item against the framing state
    always_comb begin
        is_release = (i_item.action == ACT_RELEASE);
        is_end     = (i_item.data_byte == END_BYTE);
        is_start   = (i_item.data_byte >= START_LOW) && !is_end;
        take_byte  = !is_release && (i_item.ether_type == r_protocol) &&
                     ((r_fill != '0) || is_start);
        fill_inc   = r_fill + FW'(1);
        deliver    = is_end && (MSG_LEN_W'(fill_inc) >= r_min_len);
    end

    // Advance the fill; close on end byte or on overflow
    always_comb begin
        n_fill = r_fill;
        if (i_accept && take_byte) begin
            if (is_end || (fill_inc == FW'(MAX_MESSAGE))) begin
                n_fill = '0;
            end else begin
                n_fill = fill_inc;
            end
        end
    end

    // Build the command for the back
    always_comb begin
        o_cmd_valid        = is_release || take_byte;
        o_cmd.kind         = is_release ? CMD_RELEASE : CMD_BYTE;
        o_cmd.data         = i_item.data_byte;
        o_cmd.index        = MSG_IDX_W'(r_fill);
        o_cmd.deliver      = deliver;
        o_cmd.length       = MSG_LEN_W'(fill_inc);
        o_cmd.mac          = i_item.source_mac;
        o_cmd.release_slot = i_item.release_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= PROTOCOL_RESET;
            r_min_len  <= MIN_LENGTH_RESET;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_PROTOCOL_TYPE: r_protocol <= i_cfg_data;
                CFG_MIN_LENGTH:    r_min_len  <= i_cfg_data[MSG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/fdsl_queue.sv =====
// -----------------------------------------------------------------------------
// Deframer command queue
// Short register queue that decouples the front from the back.
// -----------------------------------------------------------------------------
module fdsl_queue
    import fdsl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = $clog2(CMD_DEPTH);

    t_cmd          r_mem [CMD_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (PW + 1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers; depth is a power of two so they wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW + 1)'(1);
            end
        end
    end

endmodule

// ===== hdl/fdsl_back.sv =====
// -----------------------------------------------------------------------------
// Deframer back
// Buffers message bytes, learns source addresses and replays messages.
// -----------------------------------------------------------------------------
module fdsl_back
    import fdsl_pkg::*;
#(
    parameter int MAX_MESSAGE   = DEF_MAX_MESSAGE,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    localparam int AW = $clog2(MAX_MESSAGE);
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int RW = (TW > SLOT_W) ? TW : SLOT_W;
    localparam logic [TW-1:0] LAST_ENTRY = TW'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CMP = 6'b001000,
        S_REP_RD   = 6'b010000,
        S_REP_LD   = 6'b100000
    } t_state;

    // Memories
    logic [MAC_W-1:0] r_table [TABLE_ENTRIES];
    logic [7:0]       r_store [MAX_MESSAGE];
    logic [MAC_W-1:0] r_tbl_q;
    logic [7:0]       r_st_q;

    t_state               r_state,     n_state;
    logic [TW-1:0]        r_idx,       n_idx;
    logic [TW-1:0]        r_free_idx,  n_free_idx;
    logic                 r_have_free, n_have_free;
    logic [MSG_LEN_W-1:0] r_len,       n_len;
    logic [MAC_W-1:0]     r_mac,       n_mac;
    logic [TW-1:0]        r_slot,      n_slot;
    logic                 r_new,       n_new;
    logic                 r_full,      n_full;
    logic [AW-1:0]        r_cnt,       n_cnt;
    logic                 r_out_vld,   n_out_vld;
    t_out_item            r_out,       n_out;

    logic             tbl_we;
    logic [TW-1:0]    tbl_waddr;
    logic [MAC_W-1:0] tbl_wdata;
    logic             st_we;

    logic [RW-1:0]    rel_w;
    logic             rel_ok;
    logic             hit;
    logic             have_free_nxt;
    logic [TW-1:0]    free_nxt;
    logic             last;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_empty    = !r_out_vld;
    assign o_result   = r_out;

    // Decode the release slot and the scan compare
    always_comb begin
        rel_w         = RW'(i_cmd.release_slot);
        rel_ok        = ({1'b0, rel_w} < (RW + 1)'(TABLE_ENTRIES));
        hit           = (r_tbl_q == r_mac);
        have_free_nxt = r_have_free || (r_tbl_q == '0);
        free_nxt      = r_have_free ? r_free_idx : r_idx;
        last          = ((MSG_LEN_W'(r_cnt) + MSG_LEN_W'(1)) == r_len);
    end

    // Sequence commands, table scan and replay
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_free_idx  = r_free_idx;
        n_have_free = r_have_free;
        n_len       = r_len;
        n_mac       = r_mac;
        n_slot      = r_slot;
        n_new       = r_new;
        n_full      = r_full;
        n_cnt       = r_cnt;
        n_out_vld   = r_out_vld && !i_pop;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = r_idx;
        tbl_wdata   = '0;
        st_we       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                tbl_we = 1'b1;
                if (r_idx == LAST_ENTRY) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + TW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_RELEASE) begin
                        tbl_we    = rel_ok;
                        tbl_waddr = rel_w[TW-1:0];
                    end else begin
                        st_we = 1'b1;
                        if (i_cmd.deliver) begin
                            n_len       = i_cmd.length;
                            n_mac       = i_cmd.mac;
                            n_idx       = '0;
                            n_have_free = 1'b0;
                            n_state     = S_SCAN_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                n_cnt = '0;
                if (hit) begin
                    n_slot  = r_idx;
                    n_new   = 1'b0;
                    n_full  = 1'b0;
                    n_state = S_REP_RD;
                end else begin
                    n_have_free = have_free_nxt;
                    n_free_idx  = free_nxt;
                    if (r_idx == LAST_ENTRY) begin
                        n_state = S_REP_RD;
                        if (have_free_nxt) begin
                            // Learn the address in the first free slot
                            tbl_we    = 1'b1;
                            tbl_waddr = free_nxt;
                            tbl_wdata = r_mac;
                            n_slot    = free_nxt;
                            n_new     = 1'b1;
                            n_full    = 1'b0;
                        end else begin
                            n_slot = '0;
                            n_new  = 1'b0;
                            n_full = 1'b1;
                        end
                    end else begin
                        n_idx   = r_idx + TW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_REP_RD: begin
                n_state = S_REP_LD;
            end
            S_REP_LD: begin
                if (!r_out_vld || i_pop) begin
                    n_out_vld          = 1'b1;
                    n_out.message_byte = r_st_q;
                    n_out.address_slot = SLOT_W'(r_slot);
                    n_out.address_new  = r_new;
                    n_out.table_full   = r_full;
                    n_out.last_byte    = last;
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + AW'(1);
                        n_state = S_REP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Address table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_q <= r_table[r_idx];
    end

    // Message store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[i_cmd.index[AW-1:0]] <= i_cmd.data;
        end
        r_st_q <= r_store[r_cnt];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_free_idx  <= n_free_idx;
        r_have_free <= n_have_free;
        r_len       <= n_len;
        r_mac       <= n_mac;
        r_slot      <= n_slot;
        r_new       <= n_new;
        r_full      <= n_full;
        r_cnt       <= n_cnt;
        r_out       <= n_out;
    end

endmodule

// ===== hdl/frame_deframer_with_source_learning.sv =====
// -----------------------------------------------------------------------------
// Frame deframer with source learning
// Extracts framed messages from received payload bytes and tags each
// message byte with the learned table slot of its source address.
// -----------------------------------------------------------------------------
// After reset the block clears its address table, one entry a cycle, and keeps
// full high meanwhile. The front then takes one input transaction per cycle
// while its four-entry command queue has room. The back retires one queued
// byte or release command per cycle while idle. A message end starts a table
// search, a read and a compare state per entry scanned, up to a hit or the
// last entry (table memory with one write port and a registered read), followed
// by a read and a load state per delivered byte from the message store. Inputs
// queue up behind a search or replay until the command queue fills.
// -----------------------------------------------------------------------------
module frame_deframer_with_source_learning
    import fdsl_pkg::*;
#(
    parameter int MAX_MESSAGE   = DEF_MAX_MESSAGE,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic accept;
    logic front_valid;
    t_cmd front_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    logic clearing;

    // Accept inputs while the queue has room and the table is ready
    assign full        = q_full || clearing;
    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    fdsl_front #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_accept    (accept),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd)
    );

    fdsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && front_valid),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    fdsl_back #(
        .MAX_MESSAGE   (MAX_MESSAGE),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== hdl/fdsl_chk.sv =====
// -----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level result port over time and binds to the top level.
// -----------------------------------------------------------------------------
`include "frame_deframer_with_source_learning_assert.svh"

module fdsl_chk
    import fdsl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // Hold a waiting result until it is taken
    `FDSL_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, (!empty && !pop), (!empty && $stable(o_result)))

    // Come out of reset empty and busy clearing the table
    `FDSL_ASSERT_RST(a_reset_state, i_clk, i_rst_n, (empty && full))

    // A full table reports slot zero and no new entry
    `FDSL_ASSERT_NOW(a_full_slot, i_clk, i_rst_n, !empty, !(o_result.table_full && (o_result.address_new || (o_result.address_slot != 6'd0))))

    // A message always closes on the end byte
    `FDSL_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, (!empty && o_result.last_byte), (o_result.message_byte == END_BYTE))

endmodule

bind frame_deframer_with_source_learning fdsl_chk u_fdsl_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
